/* hdl/rbd_pkg.sv */
// Package for the ring buffer deque: command and result beat types and the
// operation and status codes. It depends on nothing else.

package rbd_pkg;

	localparam int VALUE_W = 32;
	localparam int CAP_W   = 7;
	localparam int COUNT_W = 7;

	localparam logic [1:0] MODE_PUSH_REAR  = 2'd0;
	localparam logic [1:0] MODE_PUSH_FRONT = 2'd1;
	localparam logic [1:0] MODE_POP_REAR   = 2'd2;
	localparam logic [1:0] MODE_POP_FRONT  = 2'd3;

	localparam logic [1:0] STATUS_DONE       = 2'd0;
	localparam logic [1:0] STATUS_PUSH_FULL  = 2'd1;
	localparam logic [1:0] STATUS_POP_EMPTY  = 2'd2;

	typedef struct packed {
		logic [1:0]                mode;
		logic signed [VALUE_W-1:0] push_value;
	} cmd_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] pop_value;
		logic [1:0]                status;
		logic [COUNT_W-1:0]        entry_count;
		logic                      is_full;
		logic                      is_empty;
	} result_t;

endpackage

/* hdl/ring_buffer_deque_core.sv */
// Top level of the ring buffer deque: pointer and count logic around one
// synchronous ring memory. It depends on rbd_pkg.
//
// Channel  | Handshake                 | Beat
// command  | start, busy               | cmd (cmd_t)
// result   | done (one-cycle strobe)   | result (result_t)
// config   | cfg_valid, cfg_ready      | cfg_data (capacity in use)
//
// A command is accepted on an edge with start high and busy low; its result
// is strobed on done in the following cycle, so one command per cycle is
// sustained while no configuration beat is offered. The single ring memory
// port pair (one write, one registered read) sets that latency. Reset empties
// the deque and sets capacity 64, clipped to the ring depth; the memory is not
// cleared. busy is high while a configuration beat is offered, which also
// empties the deque. The receiver cannot stall results.

module ring_buffer_deque_core
	import rbd_pkg::*;
#(
	parameter int RING_DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cmd_t             cmd,
	output logic             done,
	output result_t          result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CAP_W-1:0] cfg_data
);

	localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int DEP_W = $clog2(RING_DEPTH + 1);
	localparam int EXT_W = (DEP_W > CAP_W) ? DEP_W : CAP_W;
	localparam logic [EXT_W-1:0] DEPTH_E = EXT_W'(RING_DEPTH);
	localparam logic [EXT_W-1:0] RESET_CAP = (DEPTH_E < EXT_W'(64)) ? DEPTH_E : EXT_W'(64);

	logic [VALUE_W-1:0] ring_mem [RING_DEPTH];

	logic [EXT_W-1:0]   cap_q;
	logic [IDX_W-1:0]   front_q;
	logic [IDX_W-1:0]   rear_q;
	logic [COUNT_W-1:0] count_q;

	logic               done_q;
	logic               pop_ok_s1;
	logic [VALUE_W-1:0] rd_data_s1;
	logic [1:0]         status_s1;
	logic [COUNT_W-1:0] count_s1;
	logic               full_s1;
	logic               empty_s1;

	logic               accept;
	logic               cfg_write;
	logic               is_full_now;
	logic               is_empty_now;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [IDX_W-1:0]   rd_addr;
	logic               pop_ok;
	logic [1:0]         status_d;
	logic [IDX_W-1:0]   front_d;
	logic [IDX_W-1:0]   rear_d;
	logic [COUNT_W-1:0] count_d;
	logic [EXT_W-1:0]   cfg_cap;

	function automatic logic [IDX_W-1:0] step_fwd(input logic [IDX_W-1:0] idx,
		input logic [EXT_W-1:0] cap);
		logic [EXT_W-1:0] nxt;
		nxt = EXT_W'(idx) + EXT_W'(1);
		if (nxt >= cap) begin
			return '0;
		end
		return IDX_W'(nxt);
	endfunction

	function automatic logic [IDX_W-1:0] step_back(input logic [IDX_W-1:0] idx,
		input logic [EXT_W-1:0] cap);
		if (idx == '0 || EXT_W'(idx) > cap) begin
			return IDX_W'(cap - EXT_W'(1));
		end
		return idx - IDX_W'(1);
	endfunction

	assign busy      = cfg_valid;
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid & cfg_ready;
	assign accept    = start & ~busy;

	always_comb begin
		cfg_cap = EXT_W'(cfg_data);
		if (cfg_data == '0) begin
			cfg_cap = EXT_W'(1);
		end else if (EXT_W'(cfg_data) > DEPTH_E) begin
			cfg_cap = DEPTH_E;
		end
	end

	assign is_full_now  = EXT_W'(count_q) >= cap_q;
	assign is_empty_now = count_q == '0;

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = rear_q;
		rd_addr  = front_q;
		pop_ok   = 1'b0;
		status_d = STATUS_DONE;
		front_d  = front_q;
		rear_d   = rear_q;
		count_d  = count_q;
		case (cmd.mode)
			MODE_PUSH_REAR: begin
				if (is_full_now) begin
					status_d = STATUS_PUSH_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_addr = rear_q;
					rear_d  = step_fwd(rear_q, cap_q);
					count_d = count_q + COUNT_W'(1);
				end
			end
			MODE_PUSH_FRONT: begin
				if (is_full_now) begin
					status_d = STATUS_PUSH_FULL;
				end else begin
					wr_en   = 1'b1;
					front_d = step_back(front_q, cap_q);
					wr_addr = front_d;
					count_d = count_q + COUNT_W'(1);
				end
			end
			MODE_POP_REAR: begin
				if (is_empty_now) begin
					status_d = STATUS_POP_EMPTY;
				end else begin
					pop_ok  = 1'b1;
					rear_d  = step_back(rear_q, cap_q);
					rd_addr = rear_d;
					count_d = count_q - COUNT_W'(1);
				end
			end
			MODE_POP_FRONT: begin
				if (is_empty_now) begin
					status_d = STATUS_POP_EMPTY;
				end else begin
					pop_ok  = 1'b1;
					rd_addr = front_q;
					front_d = step_fwd(front_q, cap_q);
					count_d = count_q - COUNT_W'(1);
				end
			end
			default: begin
				status_d = STATUS_DONE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			ring_mem[wr_addr] <= cmd.push_value;
		end
		if (accept) begin
			rd_data_s1 <= ring_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= RESET_CAP;
			front_q <= '0;
			rear_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (cfg_write) begin
				cap_q   <= cfg_cap;
				front_q <= '0;
				rear_q  <= '0;
				count_q <= '0;
			end else if (accept) begin
				front_q <= front_d;
				rear_q  <= rear_d;
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pop_ok_s1 <= pop_ok;
			status_s1 <= status_d;
			count_s1  <= count_d;
			full_s1   <= EXT_W'(count_d) >= cap_q;
			empty_s1  <= count_d == '0;
		end
	end

	assign done               = done_q;
	assign result.pop_value   = pop_ok_s1 ? rd_data_s1 : '0;
	assign result.status      = status_s1;
	assign result.entry_count = count_s1;
	assign result.is_full     = full_s1;
	assign result.is_empty    = empty_s1;

endmodule
